// ===== design/spsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsl_pkg
// shared constants and types for the stable priority select list
// ----------------------------------------------------------------------------
package spsl_pkg;

  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned MOVE_W      = 16;
  localparam int unsigned PRIO_W      = 32;

  typedef enum logic [1:0] {
    OP_NEW_NODE = 2'd0,
    OP_NEW_LIST = 2'd1,
    OP_ADD      = 2'd2,
    OP_TAKE     = 2'd3
  } op_e;

  typedef struct packed {
    logic                     taken;
    logic [MOVE_W-1:0]        move;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic                     vld;
    logic [ADDR_W-1:0]        idx;
    logic [MOVE_W-1:0]        move;
    logic signed [PRIO_W-1:0] prio;
  } best_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== design/spsl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsl_ram
// generic single write port, single read port memory with registered read
// ----------------------------------------------------------------------------
module spsl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/spsl_best.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsl_best
// shared signed compare unit holding the first maximum seen during a scan
// ----------------------------------------------------------------------------
module spsl_best (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        en_i,
  input  logic [spsl_pkg::ADDR_W-1:0] idx_i,
  input  spsl_pkg::entry_t            entry_i,
  output spsl_pkg::best_t             best_o
);
  import spsl_pkg::*;

  best_t best_q, best_d;
  logic  take_new;

  // strict greater keeps the earliest entry among equal priorities
  assign take_new = en_i && !entry_i.taken && (!best_q.vld || (entry_i.prio > best_q.prio));

  always_comb begin
    best_d = best_q;
    if (clear_i) begin
      best_d.vld = 1'b0;
    end else if (take_new) begin
      best_d.vld  = 1'b1;
      best_d.idx  = idx_i;
      best_d.move = entry_i.move;
      best_d.prio = entry_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule
`default_nettype wire

// ===== design/stable_priority_select_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// new node, new list and add answer in the cycle after the transfer; the result is registered
// take with entries left does one memory read per stored entry through the
// single read port, then drain and write-back
// an exhausted take answers in the cycle after its transfer; one item is in work at a time
// reset is asynchronous active low: clears counts, excluded move and control;
// entry memory is not cleared, no clearing pass
// ----------------------------------------------------------------------------
// stable_priority_select_list
// selection list returning the highest priority untaken entry, stable order
// ----------------------------------------------------------------------------
module stable_priority_select_list (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         operation_i,
  input  logic [spsl_pkg::MOVE_W-1:0]        move_code_i,
  input  logic signed [spsl_pkg::PRIO_W-1:0] priority_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [spsl_pkg::MOVE_W-1:0]        best_move_o,
  output logic                               found_o,
  output logic                               dropped_o,
  output logic                               overflow_o
);
  import spsl_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [MOVE_W-1:0] excl_q, excl_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  taken_q, taken_d;
  logic [ADDR_W-1:0] scan_addr_q, scan_addr_d;
  logic              rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0] rd_idx_q;

  logic              out_valid_q, out_valid_d;
  logic [MOVE_W-1:0] out_move_q, out_move_d;
  logic              out_found_q, out_found_d;
  logic              out_drop_q, out_drop_d;
  logic              out_ovf_q, out_ovf_d;

  logic              in_xfer;
  op_e               op;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;
  logic              best_clr;
  best_t             best;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign op         = op_e'(operation_i);
  assign rd_entry   = ram_rdata;

  always_comb begin
    state_d     = state_q;
    excl_d      = excl_q;
    cnt_d       = cnt_q;
    taken_d     = taken_q;
    scan_addr_d = scan_addr_q;
    rd_vld_d    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[ADDR_W-1:0];
    ram_wdata   = '0;
    ram_re      = 1'b0;
    best_clr    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_move_d  = out_move_q;
    out_found_d = out_found_q;
    out_drop_d  = out_drop_q;
    out_ovf_d   = out_ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          out_move_d  = '0;
          out_found_d = 1'b0;
          out_drop_d  = 1'b0;
          out_ovf_d   = 1'b0;
          unique case (op)
            OP_NEW_NODE: begin
              excl_d      = move_code_i;
              cnt_d       = '0;
              taken_d     = '0;
              out_valid_d = 1'b1;
            end
            OP_NEW_LIST: begin
              cnt_d       = '0;
              taken_d     = '0;
              out_valid_d = 1'b1;
            end
            OP_ADD: begin
              out_valid_d = 1'b1;
              priority if ((excl_q != '0) && (move_code_i == excl_q)) begin
                out_drop_d = 1'b1;
              end else if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
                out_ovf_d = 1'b1;
              end else begin
                ram_we          = 1'b1;
                ram_wdata.taken = 1'b0;
                ram_wdata.move  = move_code_i;
                ram_wdata.prio  = priority_req_i;
                cnt_d           = cnt_q + CNT_W'(1);
              end
            end
            OP_TAKE: begin
              if (taken_q < cnt_q) begin
                state_d     = ST_SCAN;
                scan_addr_d = '0;
                best_clr    = 1'b1;
              end else begin
                out_valid_d = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_re   = 1'b1;
        rd_vld_d = 1'b1;
        if (CNT_W'(scan_addr_q) == (cnt_q - CNT_W'(1))) begin
          state_d = ST_DRAIN;
        end else begin
          scan_addr_d = scan_addr_q + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we          = 1'b1;
        ram_waddr       = best.idx;
        ram_wdata.taken = 1'b1;
        ram_wdata.move  = best.move;
        ram_wdata.prio  = best.prio;
        taken_d         = taken_q + CNT_W'(1);
        out_valid_d     = 1'b1;
        out_move_d      = best.move;
        out_found_d     = 1'b1;
        out_drop_d      = 1'b0;
        out_ovf_d       = 1'b0;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      excl_q      <= '0;
      cnt_q       <= '0;
      taken_q     <= '0;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      excl_q      <= excl_d;
      cnt_q       <= cnt_d;
      taken_q     <= taken_d;
      scan_addr_q <= scan_addr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= scan_addr_q;
    out_move_q  <= out_move_d;
    out_found_q <= out_found_d;
    out_drop_q  <= out_drop_d;
    out_ovf_q   <= out_ovf_d;
  end

  spsl_ram #(
    .Width (ENTRY_W),
    .Depth (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_addr_q),
    .rdata_o (ram_rdata)
  );

  spsl_best u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (best_clr),
    .en_i    (rd_vld_q),
    .idx_i   (rd_idx_q),
    .entry_i (rd_entry),
    .best_o  (best)
  );

  assign out_valid_o = out_valid_q;
  assign best_move_o = out_move_q;
  assign found_o     = out_found_q;
  assign dropped_o   = out_drop_q;
  assign overflow_o  = out_ovf_q;

endmodule
`default_nettype wire

// ===== design/spsl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsl_checker
// port level assertions for the stable priority select list
// ----------------------------------------------------------------------------
module spsl_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [1:0]                         operation_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [spsl_pkg::MOVE_W-1:0]        best_move_o,
  input logic                               found_o,
  input logic                               dropped_o,
  input logic                               overflow_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_move_o) && $stable(found_o))
    else $error("result changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && (dropped_o || overflow_o)) && !(dropped_o && overflow_o))
    else $error("result flags not exclusive");

  a_move_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> best_move_o == '0)
    else $error("move shown without found");

  // no new transfer while an unread result blocks the output register
  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input ready while result stalled");

  // a take with entries left never answers in the next cycle
  a_take_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == spsl_pkg::OP_TAKE)
      |=> !(out_valid_o && found_o))
    else $error("found result too early");

endmodule

bind stable_priority_select_list spsl_checker u_spsl_checker (.*);
`default_nettype wire

// ===== test/stable_priority_select_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_select_list_tb
// drives list loads, exclusions and takes through the valid/ready channels,
// predicts every response from a shadow copy of the list and checks each
// response transfer field by field, with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module stable_priority_select_list_tb;
  import spsl_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned ITEM_TARGET = 1700;

  typedef struct packed {
    logic [MOVE_W-1:0] move;
    logic              found;
    logic              dropped;
    logic              overflow;
  } list_result_t;

  class select_list_shadow;
    logic [MOVE_W-1:0]        moves[MAX_ENTRIES];
    logic signed [PRIO_W-1:0] prios[MAX_ENTRIES];
    bit                       taken[MAX_ENTRIES];
    int unsigned              count;
    logic [MOVE_W-1:0]        excluded;
    list_result_t             picks[$];
    int unsigned              mismatches;

    function new();
      count      = 0;
      excluded   = '0;
      mismatches = 0;
    endfunction

    // untaken entries keep load order, so the first maximum is the stable pick
    function void note_transfer(op_e op, logic [MOVE_W-1:0] mv, logic signed [PRIO_W-1:0] pr);
      list_result_t r;
      int           best;
      r    = '0;
      best = -1;
      case (op)
        OP_NEW_NODE: begin
          excluded = mv;
          count    = 0;
        end
        OP_NEW_LIST: begin
          count = 0;
        end
        OP_ADD: begin
          if (excluded != '0 && mv == excluded) begin
            r.dropped = 1'b1;
          end else if (count >= MAX_ENTRIES) begin
            r.overflow = 1'b1;
          end else begin
            moves[count] = mv;
            prios[count] = pr;
            taken[count] = 1'b0;
            count++;
          end
        end
        default: begin
          for (int i = 0; i < int'(count); i++) begin
            if (!taken[i] && (best < 0 || prios[i] > prios[best])) best = i;
          end
          if (best >= 0) begin
            r.move      = moves[best];
            r.found     = 1'b1;
            taken[best] = 1'b1;
          end
        end
      endcase
      picks.push_back(r);
    endfunction

    function void compare_field(string name, logic [MOVE_W-1:0] want, logic [MOVE_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_transfer(list_result_t got);
      list_result_t want;
      if (picks.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response, expected none actual %h", $time, got);
        return;
      end
      want = picks.pop_front();
      compare_field("best_move", want.move, got.move);
      compare_field("found", want.found, got.found);
      compare_field("dropped", want.dropped, got.dropped);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               operation_i    = '0;
  logic [MOVE_W-1:0]        move_code_i    = '0;
  logic signed [PRIO_W-1:0] priority_req_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [MOVE_W-1:0]        best_move_o;
  logic                     found_o;
  logic                     dropped_o;
  logic                     overflow_o;

  select_list_shadow sb = new();
  int unsigned       items_sent   = 0;
  int unsigned       burst_left   = 0;
  int unsigned       quiet_cycles = 0;
  bit                hold_go      = 1'b0;

  stable_priority_select_list uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .move_code_i    (move_code_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .best_move_o    (best_move_o),
    .found_o        (found_o),
    .dropped_o      (dropped_o),
    .overflow_o     (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_item(input op_e op, input logic [MOVE_W-1:0] mv,
                           input logic signed [PRIO_W-1:0] pr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    move_code_i    <= mv;
    priority_req_i <= pr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_transfer(op, mv, pr);
    burst_left--;
    items_sent++;
  endtask

  function automatic logic signed [PRIO_W-1:0] rand_priority();
    case ($urandom_range(0, 4))
      0:       return 32'($urandom_range(0, 3)) - 32'd2;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [MOVE_W-1:0] pick_move();
    if ($urandom_range(0, 7) == 0) return sb.excluded;
    if ($urandom_range(0, 15) == 0) return '0;
    return 16'($urandom);
  endfunction

  task automatic send_take();
    send_item(OP_TAKE, 16'($urandom), 32'($urandom));
  endtask

  // load past capacity under an exclusion, then take some or all back out
  task automatic fill_list(input bit drain_all);
    logic [MOVE_W-1:0] excl;
    excl = 16'($urandom_range(1, 65535));
    send_item(OP_NEW_NODE, excl, 32'($urandom));
    while (sb.count < MAX_ENTRIES) send_item(OP_ADD, pick_move(), rand_priority());
    send_item(OP_ADD, excl, rand_priority());
    send_item(OP_ADD, excl ^ 16'h0001, rand_priority());
    repeat ($urandom_range(1, 3)) send_item(OP_ADD, pick_move(), rand_priority());
    repeat (drain_all ? MAX_ENTRIES + 1 : 10) send_take();
  endtask

  task automatic build_and_take();
    int n;
    int takes;
    if ($urandom_range(0, 2) == 0) begin
      send_item(OP_NEW_NODE, ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom),
                32'($urandom));
    end else begin
      send_item(OP_NEW_LIST, 16'($urandom), 32'($urandom));
    end
    n = $urandom_range(1, 24);
    repeat (n) send_item(OP_ADD, pick_move(), rand_priority());
    takes = $urandom_range(0, n + 2);
    repeat (takes) begin
      if ($urandom_range(0, 5) == 0) send_item(OP_ADD, pick_move(), rand_priority());
      send_take();
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_item(op_e'($urandom_range(0, 3)), 16'($urandom), rand_priority());
    end
  endtask

  // response side: stall pattern of its own, one long hold-off on request
  initial begin
    int span;
    int mode;
    bit held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        span = $urandom_range(1, 60);
        mode = $urandom_range(0, 3);
        repeat (span) begin
          case (mode)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= 1'($urandom_range(0, 1));
            2:       out_ready_i <= 1'b0;
            default: out_ready_i <= ($urandom_range(0, 2) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    list_result_t seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen.move     = best_move_o;
        seen.found    = found_o;
        seen.dropped  = dropped_o;
        seen.overflow = overflow_o;
        sb.check_transfer(seen);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int seq;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    send_take();
    send_item(OP_ADD, 16'h0000, 32'sd0);
    send_item(OP_ADD, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(OP_ADD, 16'h0001, 32'h8000_0000);
    send_item(OP_ADD, 16'h0002, 32'sd5);
    send_item(OP_ADD, 16'h0003, 32'sd5);
    send_take();
    send_item(OP_NEW_LIST, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_ADD, 16'h0010, 32'sd7);
    send_item(OP_ADD, 16'h0011, 32'sd7);
    send_item(OP_ADD, 16'h0012, -32'sd1);
    send_take();
    send_take();
    send_item(OP_ADD, 16'h0013, 32'sd7);
    send_take();
    send_take();
    send_take();
    send_item(OP_NEW_NODE, 16'hABCD, 32'sd0);
    send_item(OP_ADD, 16'hABCD, 32'h7FFF_FFFF);
    send_item(OP_ADD, 16'h0000, 32'sd1);
    send_take();
    send_take();
    send_item(OP_NEW_NODE, 16'h0000, 32'sd0);
    send_item(OP_ADD, 16'hABCD, 32'h8000_0000);
    send_take();

    // random
    hold_go <= 1'b1;
    fill_list(1'b1);
    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      seq++;
      if (seq == 40) fill_list(1'b0);
      else if ($urandom_range(0, 9) == 0) send_noise();
      else build_and_take();
    end
    in_valid_i <= 1'b0;

    while (sb.picks.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.picks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
